[hw/rtl/tgad_pkg.sv]
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared constants and types of the tga pixel stream decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  localparam int BYTE_W     = 8;
  localparam int ENTRY_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int PIX_CNT_W  = 25;
  localparam int FILL_W     = 9;

  typedef logic [PAL_AW-1:0]  pal_addr_t;
  typedef logic [ENTRY_W-1:0] pal_entry_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_TYPE      = 3'd0,
    CFG_PIXEL_BYTES     = 3'd1,
    CFG_PALETTE_BYTES   = 3'd2,
    CFG_PALETTE_ENTRIES = 3'd3,
    CFG_PALETTE_BASE    = 3'd4,
    CFG_PIXEL_COUNT     = 3'd5
  } cfg_idx_e;

  localparam logic [2:0] IMG_RGB      = 3'd0;
  localparam logic [2:0] IMG_RLE_RGB  = 3'd1;
  localparam logic [2:0] IMG_PAL      = 3'd2;
  localparam logic [2:0] IMG_RLE_PAL  = 3'd3;
  localparam logic [2:0] IMG_GRAY     = 3'd4;
  localparam logic [2:0] IMG_RLE_GRAY = 3'd5;

  localparam logic [2:0] BYTES_ALPHA  = 3'd4;

  typedef enum logic [1:0] {
    PH_PALETTE = 2'd0,
    PH_HEADER  = 2'd1,
    PH_DATA    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] repeat_res;
    logic              last_pixel;
    logic              bad_index;
    logic              use_pal;
  } tgad_item_t;

endpackage

[hw/rtl/tgad_if.sv]
// ----------------------------------------------------------------------------
// tgad_if
// Valid/ready stream interfaces for input bytes and decoded pixels.
// ----------------------------------------------------------------------------
interface tgad_in_if import tgad_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

interface tgad_out_if import tgad_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] alpha;
  logic [BYTE_W-1:0] repeat_res;
  logic              last_pixel;
  logic              bad_index;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_res, output last_pixel, output bad_index, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_res, input last_pixel, input bad_index, output ready);
endinterface

[hw/rtl/tgad_palette_ram.sv]
// ----------------------------------------------------------------------------
// tgad_palette_ram
// Palette memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tgad_palette_ram import tgad_pkg::*; (
  input  logic       clk_i,
  input  logic       we_i,
  input  pal_addr_t  waddr_i,
  input  pal_entry_t wdata_i,
  input  logic       re_i,
  input  pal_addr_t  raddr_i,
  output pal_entry_t rdata_o
);

  pal_entry_t mem_q [PALETTE_DEPTH];
  pal_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tgad_decode.sv]
// ----------------------------------------------------------------------------
// tgad_decode
// Configuration registers, byte parser and packet state; issues palette
// writes and lookups and one pending result per transaction.
// ----------------------------------------------------------------------------
module tgad_decode import tgad_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tgad_in_if.sink               in_i,
  input  logic                  take_i,
  output logic                  item_valid_o,
  output tgad_item_t            item_o,
  output logic                  wr_en_o,
  output pal_addr_t             wr_addr_o,
  output pal_entry_t            wr_data_o,
  output logic                  rd_en_o,
  output pal_addr_t             rd_addr_o
);

  logic [2:0]           image_type_q, pixel_bytes_q, palette_bytes_q;
  logic [FILL_W-1:0]    palette_entries_q;
  logic [BYTE_W-1:0]    palette_base_q;
  logic [PIX_CNT_W-1:0] pixel_count_q;

  phase_e               phase_q, phase_d;
  logic [1:0]           bcnt_q, bcnt_d;
  logic [BYTE_W-1:0]    pl_q, pl_d;
  logic                 run_q, run_d;
  logic [23:0]          asm_q, asm_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [PIX_CNT_W-1:0] left_q, left_d;

  logic                 item_valid_q;
  tgad_item_t           item_q, item_d;
  logic                 emit;
  logic                 acc;

  function automatic logic [23:0] asm_add(logic [23:0] a, logic [7:0] b, logic [1:0] k);
    logic [23:0] r;
    case (k)
      2'd0:    r = {16'b0, b};
      2'd1:    r = a | {8'b0, b, 8'b0};
      2'd2:    r = a | {b, 16'b0};
      default: r = a;
    endcase
    return r;
  endfunction

  assign in_i.ready = !item_valid_q || take_i;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    logic [2:0]        n;
    logic [1:0]        k;
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] rep;
    logic [FILL_W-1:0] idx;
    logic              hdr;
    logic              in_range;
    phase_d  = phase_q;
    bcnt_d   = bcnt_q;
    pl_d     = pl_q;
    run_d    = run_q;
    asm_d    = asm_q;
    fill_d   = fill_q;
    left_d   = left_q;
    emit     = 1'b0;
    item_d   = '0;
    item_d.alpha      = 8'hFF;
    item_d.repeat_res = 8'd1;
    wr_en_o   = 1'b0;
    wr_addr_o = '0;
    wr_data_o = '0;
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    d        = in_i.data_byte;
    k        = bcnt_q;
    n        = 3'd3;
    rep      = 8'd1;
    idx      = '0;
    hdr      = 1'b0;
    in_range = 1'b0;
    if (acc) begin
      if (in_i.start_of_image) begin
        fill_d  = '0;
        bcnt_d  = '0;
        pl_d    = '0;
        run_d   = 1'b0;
        asm_d   = '0;
        left_d  = pixel_count_q;
        phase_d = PH_PALETTE;
      end
      k = bcnt_d;
      if (left_d != '0 && image_type_q <= IMG_RLE_GRAY) begin
        if (phase_d == PH_PALETTE &&
            (image_type_q == IMG_PAL || image_type_q == IMG_RLE_PAL) &&
            fill_d < palette_entries_q) begin
          n = (palette_bytes_q == BYTES_ALPHA) ? 3'd4 : 3'd3;
          if ({1'b0, k} + 3'd1 < n) begin
            asm_d  = asm_add(asm_d, d, k);
            bcnt_d = k + 2'd1;
          end else begin
            bcnt_d = '0;
            if (32'(fill_d) < PALETTE_DEPTH) begin
              wr_en_o   = 1'b1;
              wr_addr_o = PAL_AW'(fill_d);
            end
            wr_data_o = (n == 3'd3) ? {8'hFF, d, asm_d[15:0]} : {d, asm_d};
            fill_d = fill_d + 9'd1;
            if (fill_d >= palette_entries_q) begin
              phase_d = PH_HEADER;
            end
          end
        end else begin
          if (phase_d == PH_PALETTE) begin
            bcnt_d  = '0;
            phase_d = PH_HEADER;
          end
          if (phase_d != PH_DATA) begin
            bcnt_d  = '0;
            phase_d = PH_DATA;
            if (image_type_q[0]) begin
              hdr = 1'b1;
              if (d[7]) begin
                run_d = 1'b1;
                pl_d  = d - 8'd127;
              end else begin
                run_d = 1'b0;
                pl_d  = d + 8'd1;
              end
            end
          end
          k = bcnt_d;
          if (!hdr) begin
            n = (image_type_q <= IMG_RLE_RGB) ?
                ((pixel_bytes_q == BYTES_ALPHA) ? 3'd4 : 3'd3) : 3'd1;
            if ({1'b0, k} + 3'd1 < n) begin
              asm_d  = asm_add(asm_d, d, k);
              bcnt_d = k + 2'd1;
            end else begin
              bcnt_d = '0;
              emit   = 1'b1;
              if (image_type_q <= IMG_RLE_RGB) begin
                item_d.blue  = asm_d[7:0];
                item_d.green = asm_d[15:8];
                if (n == 3'd3) begin
                  item_d.red = d;
                end else begin
                  item_d.red   = asm_d[23:16];
                  item_d.alpha = d;
                end
              end else if (image_type_q <= IMG_RLE_PAL) begin
                idx      = {1'b0, palette_base_q} + {1'b0, d};
                in_range = (idx < fill_d) && (32'(idx) < PALETTE_DEPTH);
                if (in_range) begin
                  rd_en_o        = 1'b1;
                  rd_addr_o      = PAL_AW'(idx);
                  item_d.use_pal = 1'b1;
                end else begin
                  item_d.bad_index = 1'b1;
                end
              end else begin
                item_d.red   = d;
                item_d.green = d;
                item_d.blue  = d;
              end
              if (image_type_q[0]) begin
                if (run_d) begin
                  rep     = pl_d;
                  phase_d = PH_HEADER;
                end else if (pl_d <= 8'd1) begin
                  pl_d    = '0;
                  phase_d = PH_HEADER;
                end else begin
                  pl_d = pl_d - 8'd1;
                end
              end
              if ({17'b0, rep} > left_d) begin
                rep = left_d[7:0];
              end
              if (rep == '0) begin
                rep = 8'd1;
              end
              left_d = left_d - {17'b0, rep};
              item_d.repeat_res = rep;
              item_d.last_pixel = (left_d == '0);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_type_q      <= IMG_RGB;
      pixel_bytes_q     <= 3'd3;
      palette_bytes_q   <= 3'd3;
      palette_entries_q <= '0;
      palette_base_q    <= '0;
      pixel_count_q     <= 25'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_TYPE:      image_type_q      <= cfg_data_i[2:0];
        CFG_PIXEL_BYTES:     pixel_bytes_q     <= cfg_data_i[2:0];
        CFG_PALETTE_BYTES:   palette_bytes_q   <= cfg_data_i[2:0];
        CFG_PALETTE_ENTRIES: palette_entries_q <= cfg_data_i[FILL_W-1:0];
        CFG_PALETTE_BASE:    palette_base_q    <= cfg_data_i[BYTE_W-1:0];
        CFG_PIXEL_COUNT:     pixel_count_q     <= cfg_data_i[PIX_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      bcnt_q       <= '0;
      pl_q         <= '0;
      run_q        <= 1'b0;
      asm_q        <= '0;
      fill_q       <= '0;
      left_q       <= '0;
      item_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bcnt_q  <= bcnt_d;
      pl_q    <= pl_d;
      run_q   <= run_d;
      asm_q   <= asm_d;
      fill_q  <= fill_d;
      left_q  <= left_d;
      if (acc) begin
        item_valid_q <= emit;
      end else if (take_i) begin
        item_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

[hw/rtl/tgad_pixel_out.sv]
// ----------------------------------------------------------------------------
// tgad_pixel_out
// Merges palette read data into the pending result and holds the output
// transaction until it is taken.
// ----------------------------------------------------------------------------
module tgad_pixel_out import tgad_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  tgad_item_t item_i,
  input  pal_entry_t rd_data_i,
  output logic       take_o,
  tgad_out_if.source out_o
);

  logic              out_valid_q;
  logic [BYTE_W-1:0] red_q, green_q, blue_q, alpha_q, rep_q;
  logic              last_q, bad_q;

  assign take_o = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && item_valid_i) begin
      if (item_i.use_pal) begin
        blue_q  <= rd_data_i[7:0];
        green_q <= rd_data_i[15:8];
        red_q   <= rd_data_i[23:16];
        alpha_q <= rd_data_i[31:24];
      end else begin
        blue_q  <= item_i.blue;
        green_q <= item_i.green;
        red_q   <= item_i.red;
        alpha_q <= item_i.alpha;
      end
      rep_q  <= item_i.repeat_res;
      last_q <= item_i.last_pixel;
      bad_q  <= item_i.bad_index;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.red        = red_q;
  assign out_o.green      = green_q;
  assign out_o.blue       = blue_q;
  assign out_o.alpha      = alpha_q;
  assign out_o.repeat_res = rep_q;
  assign out_o.last_pixel = last_q;
  assign out_o.bad_index  = bad_q;

endmodule

[hw/rtl/tga_pixel_stream_decoder_top.sv]
// The decoder takes one byte per clock cycle while input ready is high. Input
// ready drops only when a decoded pixel waits at the output and a second
// decoded pixel is already pending behind it. The edge that accepts the byte
// completing a result registers the pending result and the palette memory
// read; the output register is loaded from them once the output can take a
// new pixel. Palette entries are written into that memory as their last
// byte arrives and can be looked up from the next byte on. The palette memory
// is not cleared: only entries loaded for the current image are ever read, so
// there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_top
// TGA pixel data decoder: raw, run-length, palette and grayscale to RGBA.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_top import tgad_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tgad_in_if.sink               in_i,
  tgad_out_if.source            out_o
);

  logic       take;
  logic       item_valid;
  tgad_item_t item;
  logic       wr_en, rd_en;
  pal_addr_t  wr_addr, rd_addr;
  pal_entry_t wr_data, rd_data;

  tgad_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr)
  );

  tgad_palette_ram u_palette_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tgad_pixel_out u_pixel_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .rd_data_i    (rd_data),
    .take_o       (take),
    .out_o        (out_o)
  );

endmodule
